>>> sv/lru_pkg.sv
package lru_pkg;

    localparam int TableEntries = 1024;
    localparam int IdW          = 10;
    localparam int SizeW        = 48;
    localparam int StampW       = 48;
    localparam int TimeW        = 32;
    localparam int CountW       = 11;
    localparam int LimitW       = 6;
    localparam int MaxSelect    = 32;

    localparam logic [3:0] MODE_ACCESS  = 4'd0;
    localparam logic [3:0] MODE_HYDRATE = 4'd1;
    localparam logic [3:0] MODE_REMOVE  = 4'd2;
    localparam logic [3:0] MODE_REMOTE  = 4'd3;
    localparam logic [3:0] MODE_EVICTED = 4'd4;
    localparam logic [3:0] MODE_WBLOCK  = 4'd5;
    localparam logic [3:0] MODE_TICK    = 4'd6;
    localparam logic [3:0] MODE_SELECT  = 4'd7;
    localparam logic [3:0] MODE_QUERY   = 4'd8;

    // candidate compare unit request
    typedef struct packed {
        logic              have_prev;
        logic [StampW-1:0] prev_stamp;
        logic [IdW-1:0]    prev_id;
        logic              got;
        logic [StampW-1:0] best_stamp;
    } t_cmp_req;

    // per-chunk flags, one memory word
    typedef struct packed {
        logic wblk;
        logic evict;
        logic hyd;
        logic remote;
        logic valid;
    } t_flags;

endpackage

>>> sv/lru_ram.sv
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/lru_cmp.sv
module lru_cmp (
    input  lru_pkg::t_cmp_req                i_req,
    input  logic                             i_elig,
    input  logic [lru_pkg::StampW-1:0]       i_stamp,
    input  logic [lru_pkg::IdW-1:0]          i_id,
    output logic                             o_take
);
    logic after_prev;

    always_comb begin
        after_prev = !i_req.have_prev || (i_stamp > i_req.prev_stamp) ||
                     ((i_stamp == i_req.prev_stamp) && (i_id > i_req.prev_id));
        o_take = i_elig && after_prev && (!i_req.got || (i_stamp < i_req.best_stamp));
    end
endmodule

>>> sv/lru_eviction_candidate_table.sv
// Eviction candidate table: 1024 directly indexed chunks, LRU order with a
// post-hydration cooldown. After reset all 1024 flag words are cleared with
// busy high. An item other than select keeps busy high through a memory read
// and an update, and its result follows in the cycle after the update.
// A select starts with a read state, then makes one full pass over the table
// per candidate, and a found candidate then has its size read; one last pass
// finds nothing unless max_count (capped at 32) is reached first. A select
// with max_count zero makes no pass and returns one empty result.
// A candidate goes out when the following pass ends, so its last flag is
// known, or at once when it reaches max_count. busy is high throughout.
// Results appear on o_valid for one cycle each and cannot be stalled.
module lru_eviction_candidate_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [31:0]                  i_cfg_wdata,
    input  logic [3:0]                   i_mode,
    input  logic [lru_pkg::IdW-1:0]      i_chunk_id,
    input  logic [lru_pkg::SizeW-1:0]    i_chunk_size,
    input  logic                         i_flag_value,
    input  logic [lru_pkg::LimitW-1:0]   i_sel_limit,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [lru_pkg::IdW-1:0]      o_cand_chunk_id,
    output logic [lru_pkg::SizeW-1:0]    o_cand_chunk_size,
    output logic                         o_in_cooldown,
    output logic [lru_pkg::CountW-1:0]   o_tracked_count,
    output logic                         o_last_result
);
    localparam int N  = lru_pkg::TableEntries;
    localparam int IW = lru_pkg::IdW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_PASS = 3'd4;
    localparam logic [2:0] S_SZ   = 3'd5;
    localparam logic [2:0] S_SZ2  = 3'd6;
    localparam logic [2:0] S_CLR  = 3'd7;

    logic [2:0] r_state;
    logic [31:0] r_cool, r_secs;
    logic [lru_pkg::StampW-1:0] r_seq;
    logic [lru_pkg::CountW-1:0] r_count, n_count;

    logic [3:0] r_mode;
    logic [IW-1:0] r_id;
    logic [lru_pkg::SizeW-1:0] r_size;
    logic r_flag;
    logic [lru_pkg::LimitW-1:0] r_limit, r_n;

    // scan
    logic [IW:0] r_addr;     // issued read address counter, also clear counter
    logic r_rv;              // read data valid
    logic [IW-1:0] r_rid;    // id of data on read port
    lru_pkg::t_cmp_req r_req;
    logic [IW-1:0] r_best;

    // memories
    logic stamp_we, time_we, size_we, flag_we;
    logic [IW-1:0] raddr, size_raddr, flag_waddr;
    logic [lru_pkg::StampW-1:0] stamp_q;
    logic [31:0] time_q;
    logic [lru_pkg::SizeW-1:0] size_q;
    lru_pkg::t_flags flags_q, n_flags;

    lru_ram #(.WIDTH(lru_pkg::StampW), .DEPTH(N)) u_stamp (
        .i_clk(i_clk), .i_we(stamp_we), .i_waddr(r_id), .i_wdata(r_seq),
        .i_raddr(raddr), .o_rdata(stamp_q));
    lru_ram #(.WIDTH(32), .DEPTH(N)) u_time (
        .i_clk(i_clk), .i_we(time_we), .i_waddr(r_id), .i_wdata(r_secs),
        .i_raddr(raddr), .o_rdata(time_q));
    lru_ram #(.WIDTH(lru_pkg::SizeW), .DEPTH(N)) u_size (
        .i_clk(i_clk), .i_we(size_we), .i_waddr(r_id), .i_wdata(r_size),
        .i_raddr(size_raddr), .o_rdata(size_q));
    lru_ram #(.WIDTH($bits(lru_pkg::t_flags)), .DEPTH(N)) u_flags (
        .i_clk(i_clk), .i_we(flag_we), .i_waddr(flag_waddr), .i_wdata(n_flags),
        .i_raddr(raddr), .o_rdata(flags_q));

    logic cooling, elig, take;
    always_comb begin
        cooling = flags_q.hyd && ((r_secs - time_q) < r_cool);
        elig = r_rv && flags_q.valid && flags_q.remote && !flags_q.evict
               && !flags_q.wblk && !cooling;
    end

    lru_cmp u_cmp (.i_req(r_req), .i_elig(elig), .i_stamp(stamp_q), .i_id(r_rid),
                   .o_take(take));

    assign raddr = (r_state == S_SCAN) ? r_addr[IW-1:0] : r_id;
    assign size_raddr = r_best;
    assign flag_waddr = (r_state == S_CLR) ? r_addr[IW-1:0] : r_id;
    assign busy = (r_state != S_IDLE);

    always_comb begin
        stamp_we = 1'b0;
        time_we  = 1'b0;
        size_we  = 1'b0;
        flag_we  = 1'b0;
        n_flags  = flags_q;
        n_count  = r_count;
        if (r_state == S_CLR) begin
            flag_we = 1'b1;
            n_flags = '0;
        end else if (r_state == S_UPD) begin
            stamp_we = (r_mode == lru_pkg::MODE_ACCESS) ||
                       ((r_mode == lru_pkg::MODE_HYDRATE) && flags_q.valid);
            time_we  = (r_mode == lru_pkg::MODE_HYDRATE) && flags_q.valid;
            size_we  = (r_mode == lru_pkg::MODE_ACCESS);
            case (r_mode)
                lru_pkg::MODE_ACCESS: begin
                    flag_we = 1'b1;
                    if (!flags_q.valid) begin
                        n_flags.valid  = 1'b1;
                        n_flags.remote = 1'b0;
                        n_flags.hyd    = 1'b0;
                        n_count = r_count + 1'b1;
                    end
                end
                lru_pkg::MODE_HYDRATE: begin
                    flag_we = 1'b1;
                    if (flags_q.valid) n_flags.hyd = 1'b1;
                end
                lru_pkg::MODE_REMOVE: begin
                    flag_we = 1'b1;
                    if (flags_q.valid) begin
                        n_flags.valid  = 1'b0;
                        n_flags.remote = 1'b0;
                        n_flags.hyd    = 1'b0;
                        n_count = r_count - 1'b1;
                    end
                end
                lru_pkg::MODE_REMOTE: begin
                    flag_we = 1'b1;
                    if (flags_q.valid) n_flags.remote = 1'b1;
                end
                lru_pkg::MODE_EVICTED: begin
                    flag_we = 1'b1;
                    n_flags.evict = r_flag;
                end
                lru_pkg::MODE_WBLOCK: begin
                    flag_we = 1'b1;
                    n_flags.wblk = r_flag;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr <= '0;
            r_cool <= '0; r_secs <= '0; r_seq <= '0; r_count <= '0;
            o_valid <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cool <= i_cfg_wdata;
            end
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr[IW-1:0] == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode <= i_mode; r_id <= i_chunk_id; r_size <= i_chunk_size;
                        r_flag <= i_flag_value;
                        r_limit <= (i_sel_limit > lru_pkg::LimitW'(lru_pkg::MaxSelect))
                                   ? lru_pkg::LimitW'(lru_pkg::MaxSelect) : i_sel_limit;
                        r_n <= '0;
                        r_req <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_mode == lru_pkg::MODE_SELECT) begin
                        if (r_limit == '0) begin
                            r_state <= S_UPD;
                        end else begin
                            r_addr <= '0; r_rv <= 1'b0;
                            r_req.got <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    o_found <= 1'b0; o_cand_chunk_id <= '0; o_cand_chunk_size <= '0;
                    o_in_cooldown <= (r_mode == lru_pkg::MODE_QUERY) && flags_q.valid
                                     && cooling;
                    o_last_result <= 1'b1; o_valid <= 1'b1;
                    o_tracked_count <= n_count;
                    r_count <= n_count;
                    if (stamp_we) begin
                        r_seq <= r_seq + 1'b1;
                    end
                    if (r_mode == lru_pkg::MODE_TICK) begin
                        r_secs <= r_secs + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_rv <= !r_addr[IW];
                    r_rid <= r_addr[IW-1:0];
                    if (!r_addr[IW]) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (take) begin
                        r_req.got <= 1'b1;
                        r_req.best_stamp <= stamp_q;
                        r_best <= r_rid;
                    end
                    if (r_addr[IW] && !r_rv) begin
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    // held candidate goes out now that this pass tells if it is last
                    if (r_n != '0) begin
                        o_valid <= 1'b1;
                        o_last_result <= !r_req.got;
                    end
                    if (!r_req.got) begin
                        if (r_n == '0) begin
                            r_state <= S_UPD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_SZ;
                    end
                end
                S_SZ: r_state <= S_SZ2;
                S_SZ2: begin
                    o_found <= 1'b1;
                    o_cand_chunk_id <= r_best; o_cand_chunk_size <= size_q;
                    o_in_cooldown <= 1'b0; o_tracked_count <= r_count;
                    o_last_result <= 1'b1;
                    r_req.have_prev <= 1'b1;
                    r_req.prev_stamp <= r_req.best_stamp;
                    r_req.prev_id <= r_best;
                    r_req.got <= 1'b0;
                    r_n <= r_n + 1'b1;
                    if (r_n + 1'b1 == r_limit) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= '0; r_rv <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lru_pkg::CountW'(N)) else $error("count overflow");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_valid || $past(r_state) != S_IDLE) else $error("stray result");
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last_result) else $error("empty not last");
`endif
endmodule

>>> bench/lru_eviction_candidate_table_tb.sv
`timescale 1ns / 1ps

module lru_eviction_candidate_table_tb;

    localparam logic [3:0] ModeUnusedLo = 4'd9;
    localparam logic [3:0] ModeUnusedHi = 4'd15;
    localparam int         StallLimit   = 40000;

    typedef struct {
        logic                       found;
        logic [lru_pkg::IdW-1:0]    id;
        logic [lru_pkg::SizeW-1:0]  size;
        logic                       cool;
        logic [lru_pkg::CountW-1:0] count;
        logic                       last;
    } t_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_cfg_we;
    logic [31:0]                 i_cfg_wdata;
    logic [3:0]                  i_mode;
    logic [lru_pkg::IdW-1:0]     i_chunk_id;
    logic [lru_pkg::SizeW-1:0]   i_chunk_size;
    logic                        i_flag_value;
    logic [lru_pkg::LimitW-1:0]  i_sel_limit;
    logic                        o_valid;
    logic                        o_found;
    logic [lru_pkg::IdW-1:0]     o_cand_chunk_id;
    logic [lru_pkg::SizeW-1:0]   o_cand_chunk_size;
    logic                        o_in_cooldown;
    logic [lru_pkg::CountW-1:0]  o_tracked_count;
    logic                        o_last_result;

    lru_eviction_candidate_table uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_mode            (i_mode),
        .i_chunk_id        (i_chunk_id),
        .i_chunk_size      (i_chunk_size),
        .i_flag_value      (i_flag_value),
        .i_sel_limit       (i_sel_limit),
        .o_valid           (o_valid),
        .o_found           (o_found),
        .o_cand_chunk_id   (o_cand_chunk_id),
        .o_cand_chunk_size (o_cand_chunk_size),
        .o_in_cooldown     (o_in_cooldown),
        .o_tracked_count   (o_tracked_count),
        .o_last_result     (o_last_result)
    );

    // shadow table
    logic                       tbl_valid   [lru_pkg::TableEntries];
    logic                       tbl_remote  [lru_pkg::TableEntries];
    logic                       tbl_hyd     [lru_pkg::TableEntries];
    logic [lru_pkg::TimeW-1:0]  tbl_htime   [lru_pkg::TableEntries];
    logic [lru_pkg::StampW-1:0] tbl_stamp   [lru_pkg::TableEntries];
    logic [lru_pkg::SizeW-1:0]  tbl_size    [lru_pkg::TableEntries];
    logic                       tbl_evicted [lru_pkg::TableEntries];
    logic                       tbl_wblock  [lru_pkg::TableEntries];
    logic [lru_pkg::TimeW-1:0]  seconds_now;
    logic [lru_pkg::StampW-1:0] next_stamp;
    logic [lru_pkg::CountW-1:0] live_chunks;
    logic [31:0]                cooldown_len;

    t_result pending_results[$];
    int      mismatches;
    int      quiet_cycles;
    bit      no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit cooling(int i);
        logic [lru_pkg::TimeW-1:0] age;
        age = seconds_now - tbl_htime[i];
        return tbl_hyd[i] && (age < cooldown_len);
    endfunction

    function automatic bit evictable(int i);
        return tbl_valid[i] && tbl_remote[i] && !tbl_evicted[i] && !tbl_wblock[i]
            && !cooling(i);
    endfunction

    function automatic void push_result(logic f, logic [lru_pkg::IdW-1:0] id,
                                        logic [lru_pkg::SizeW-1:0] sz,
                                        logic c, logic l);
        t_result r;
        r.found = f; r.id = id; r.size = sz; r.cool = c; r.count = live_chunks; r.last = l;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void restamp(int i);
        tbl_stamp[i] = next_stamp;
        next_stamp   = next_stamp + 1'b1;
    endfunction

    function automatic void predict_request(logic [3:0] md, logic [lru_pkg::IdW-1:0] id,
                                            logic [lru_pkg::SizeW-1:0] sz, logic fl,
                                            logic [lru_pkg::LimitW-1:0] mc);
        int limit, n, best;
        bit have_prev, got;
        logic [lru_pkg::StampW-1:0] prev_stamp, best_stamp;
        int prev_id;
        logic c;
        c = 1'b0;
        case (md)
            lru_pkg::MODE_ACCESS: begin
                if (!tbl_valid[id]) begin
                    tbl_valid[id] = 1'b1; tbl_remote[id] = 1'b0; tbl_hyd[id] = 1'b0;
                    live_chunks++;
                end
                tbl_size[id] = sz;
                restamp(id);
            end
            lru_pkg::MODE_HYDRATE: if (tbl_valid[id]) begin
                tbl_hyd[id] = 1'b1; tbl_htime[id] = seconds_now;
                restamp(id);
            end
            lru_pkg::MODE_REMOVE: if (tbl_valid[id]) begin
                tbl_valid[id] = 1'b0; tbl_remote[id] = 1'b0; tbl_hyd[id] = 1'b0;
                live_chunks--;
            end
            lru_pkg::MODE_REMOTE:  if (tbl_valid[id]) tbl_remote[id] = 1'b1;
            lru_pkg::MODE_EVICTED: tbl_evicted[id] = fl;
            lru_pkg::MODE_WBLOCK:  tbl_wblock[id] = fl;
            lru_pkg::MODE_TICK:    seconds_now++;
            lru_pkg::MODE_QUERY:   if (tbl_valid[id]) c = cooling(id);
            lru_pkg::MODE_SELECT: begin
                limit = (mc > lru_pkg::MaxSelect) ? lru_pkg::MaxSelect : mc;
                n = 0; have_prev = 0; prev_stamp = '0; prev_id = 0;
                while (n < limit) begin
                    got = 0; best = 0; best_stamp = '0;
                    for (int i = 0; i < lru_pkg::TableEntries; i++) begin
                        if (!evictable(i)) continue;
                        if (have_prev && (tbl_stamp[i] < prev_stamp ||
                            (tbl_stamp[i] == prev_stamp && i <= prev_id))) continue;
                        if (!got || tbl_stamp[i] < best_stamp) begin
                            got = 1; best_stamp = tbl_stamp[i]; best = i;
                        end
                    end
                    if (!got) break;
                    push_result(1'b1, lru_pkg::IdW'(best), tbl_size[best], 1'b0, 1'b0);
                    n++;
                    have_prev = 1; prev_stamp = best_stamp; prev_id = best;
                end
                if (n == 0) push_result(1'b0, '0, '0, 1'b0, 1'b1);
                else pending_results[$].last = 1'b1;
                return;
            end
            default: ;
        endcase
        push_result(1'b0, '0, '0, c, 1'b1);
    endfunction

    task automatic send_request(logic [3:0] md, logic [lru_pkg::IdW-1:0] id,
                                logic [lru_pkg::SizeW-1:0] sz,
                                logic fl, logic [lru_pkg::LimitW-1:0] mc);
        if (!no_idle && $urandom_range(99) < 31) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        @(negedge i_clk);
        start = 1'b1; i_mode = md; i_chunk_id = id; i_chunk_size = sz;
        i_flag_value = fl; i_sel_limit = mc;
        do @(posedge i_clk); while (busy);
        predict_request(md, id, sz, fl, mc);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_cooldown(logic [31:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cooldown_len = v;
    endtask

    function automatic logic [lru_pkg::SizeW-1:0] rand_size();
        return {16'($urandom_range(16'hffff)), $urandom()};
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result id=%0d", o_cand_chunk_id);
            end else begin
                e = pending_results.pop_front();
                if (o_found !== e.found || o_cand_chunk_id !== e.id ||
                    o_cand_chunk_size !== e.size || o_in_cooldown !== e.cool ||
                    o_tracked_count !== e.count || o_last_result !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp f=%0b id=%0d sz=%h c=%0b n=%0d l=%0b,",
                                  " got f=%0b id=%0d sz=%h c=%0b n=%0d l=%0b"},
                            e.found, e.id, e.size, e.cool, e.count, e.last,
                            o_found, o_cand_chunk_id, o_cand_chunk_size, o_in_cooldown,
                            o_tracked_count, o_last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("lru_eviction_candidate_table_tb: done, errors");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_QUERY, 10'd1023, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_REMOVE, 10'd5, '0, 1'b0, 6'd1);
        send_request(ModeUnusedHi, 10'd1023, '1, 1'b1, 6'd63);
    endtask

    task automatic test_basic_ops();
        send_request(lru_pkg::MODE_ACCESS, 10'd0, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_ACCESS, 10'd1023, '1, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_ACCESS, 10'd7, 48'h1234_5678_9abc, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_REMOTE, 10'd0, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_REMOTE, 10'd1023, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_REMOTE, 10'd7, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_REMOTE, 10'd9, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd0);
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd63);
        send_request(lru_pkg::MODE_EVICTED, 10'd0, '0, 1'b1, 6'd1);
        send_request(lru_pkg::MODE_WBLOCK, 10'd7, '0, 1'b1, 6'd1);
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd2);
        send_request(lru_pkg::MODE_EVICTED, 10'd0, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_WBLOCK, 10'd7, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_REMOVE, 10'd1023, '0, 1'b0, 6'd1);
        send_request(ModeUnusedLo, 10'd3, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd32);
    endtask

    task automatic test_cooldown();
        write_cooldown(32'd2);
        send_request(lru_pkg::MODE_HYDRATE, 10'd7, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_QUERY, 10'd7, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd4);
        send_request(lru_pkg::MODE_TICK, '0, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_TICK, '0, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_QUERY, 10'd7, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_SELECT, '0, '0, 1'b0, 6'd4);
        write_cooldown(32'hffff_ffff);
        send_request(lru_pkg::MODE_QUERY, 10'd7, '0, 1'b0, 6'd1);
        send_request(lru_pkg::MODE_HYDRATE, 10'd55, '0, 1'b0, 6'd1);
    endtask

    task automatic test_random(int items);
        logic [3:0]                 md;
        logic [lru_pkg::IdW-1:0]    id;
        logic [lru_pkg::LimitW-1:0] mc;
        int                         r;
        for (int k = 0; k < items; k++) begin
            no_idle = (k >= items / 3) && (k < items / 2);
            r = $urandom_range(99);
            if      (r < 25) md = lru_pkg::MODE_ACCESS;
            else if (r < 35) md = lru_pkg::MODE_HYDRATE;
            else if (r < 41) md = lru_pkg::MODE_REMOVE;
            else if (r < 56) md = lru_pkg::MODE_REMOTE;
            else if (r < 62) md = lru_pkg::MODE_EVICTED;
            else if (r < 68) md = lru_pkg::MODE_WBLOCK;
            else if (r < 78) md = lru_pkg::MODE_TICK;
            else if (r < 84) md = lru_pkg::MODE_SELECT;
            else if (r < 97) md = lru_pkg::MODE_QUERY;
            else             md = 4'($urandom_range(ModeUnusedLo, ModeUnusedHi));
            id = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                          : 10'($urandom_range(15));
            mc = ($urandom_range(19) == 0) ? 6'($urandom_range(63))
                                           : 6'($urandom_range(1, 4));
            send_request(md, id, rand_size(), 1'($urandom_range(1)), mc);
            if (k == items / 4) drain();
        end
        no_idle = 0;
    endtask

    initial begin
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        i_mode = '0; i_chunk_id = '0; i_chunk_size = '0; i_flag_value = 1'b0;
        i_sel_limit = '0;
        mismatches = 0; no_idle = 0;
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 0; tbl_remote[i] = 0; tbl_hyd[i] = 0; tbl_htime[i] = '0;
            tbl_stamp[i] = '0; tbl_size[i] = '0; tbl_evicted[i] = 0; tbl_wblock[i] = 0;
        end
        seconds_now = '0; next_stamp = '0; live_chunks = '0; cooldown_len = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_basic_ops();
        test_cooldown();
        write_cooldown(32'd0);
        test_random(80);
        write_cooldown(32'd3);
        test_random(80);
        write_cooldown(32'hffff_ffff);
        test_random(80);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("lru_eviction_candidate_table_tb: done, clean");
        end else begin
            $display("lru_eviction_candidate_table_tb: done, errors");
        end
        $finish;
    end

endmodule
